// ===== rtl/pngu_pkg.sv =====
// ----------------------------------------------------------------------------
// pngu_pkg
// shared types and constants for the png scanline unfilter
// ----------------------------------------------------------------------------
package pngu_pkg;

	// default build sizes
	localparam int MAX_ROW_BYTES_DEF   = 16384;
	localparam int MAX_PIXEL_BYTES_DEF = 8;

	// field and register widths
	localparam int BYTE_W        = 8;
	localparam int PIXEL_BYTES_W = 4;
	localparam int ROW_BYTES_W   = 15;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	// register reset values
	localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = 4'd4;
	localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_RST   = 15'd4096;

	// register select, taken from paddr bit 2
	localparam logic REG_PIXEL_BYTES = 1'b0;
	localparam logic REG_ROW_BYTES   = 1'b1;

	// row filter types; bad marks an undefined type passed through as none
	typedef enum logic [2:0] {
		FILTER_NONE    = 3'd0,
		FILTER_SUB     = 3'd1,
		FILTER_UP      = 3'd2,
		FILTER_AVERAGE = 3'd3,
		FILTER_PAETH   = 3'd4,
		FILTER_BAD     = 3'd5
	} filter_t;

	// one reconstructed byte as queued for the output channel
	typedef struct packed {
		logic              bad_filter;
		logic              row_end;
		logic [BYTE_W-1:0] pixel_byte;
	} result_t;

endpackage

// ===== rtl/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// reconstructs png scanlines from the inflated filtered byte stream
// ----------------------------------------------------------------------------
// input stream: one filtered byte per transfer on s_*; s_tuser marks the first
// byte of an image. the first byte of every row is its filter type and yields
// no output transfer; every data byte yields one reconstructed byte on m_*,
// with m_tlast on the last byte of the row and m_tuser set for every byte of a
// row whose filter type was above paeth (that row passes through unfiltered).
// pixel_bytes and row_bytes are set over the apb port; write them only while
// the block is idle, as the block does not enforce it. throughput: one byte
// per cycle while the fifo has room, set by the left-neighbor loop through the
// history registers. a data byte reads the line store at acceptance, is
// reconstructed and written back from the stage, and shows on m_* via the fifo.
// stall: results queue in a four-entry output fifo; s_tready drops once the
// fifo plus the byte in flight fill it, and is independent of m_tready.
// reset: clears control state and config to defaults; the next byte is taken
// as a filter byte of row zero. the line store is not cleared: row zero has no
// row above, and each later row reads only what the row before it wrote.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
	import pngu_pkg::*;
#(
	parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
	input  logic [0:0]            s_tuser,   // [0] image_start
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [BYTE_W-1:0]     m_tdata,   // [7:0] pixel_byte
	output logic                  m_tlast,   // row_end
	output logic [0:0]            m_tuser,   // [0] bad_filter
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int AW       = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int HW       = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int OF_DEPTH = 4;
	localparam int OF_AW    = 2;
	localparam int OF_CW    = 3;

	// config registers
	logic [PIXEL_BYTES_W-1:0] pixel_bytes_q;
	logic [ROW_BYTES_W-1:0]   row_bytes_q;

	// row control
	logic          awaiting_q;
	logic          first_row_q;
	logic [AW-1:0] col_q;
	filter_t       filter_q;

	// reconstruct stage
	logic              valid_s1;
	logic [BYTE_W-1:0] raw_s1;
	logic [AW-1:0]     col_s1;
	logic              last_s1;
	logic              first_s1;
	filter_t           filter_s1;
	logic              use_left_s1;
	logic [HW-1:0]     hidx_s1;
	logic              fwd_s1;
	logic [BYTE_W-1:0] fwd_data_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	// line store and neighbor history
	logic [BYTE_W-1:0] row_mem_q [MAX_ROW_BYTES];
	logic [BYTE_W-1:0] left_hist_q [MAX_PIXEL_BYTES];
	logic [BYTE_W-1:0] upper_hist_q [MAX_PIXEL_BYTES];

	// output fifo
	result_t          fifo_q [OF_DEPTH];
	logic [OF_AW-1:0] wr_ptr_q;
	logic [OF_AW-1:0] rd_ptr_q;
	logic [OF_CW-1:0] cnt_q;

	logic                     in_xfer;
	logic                     await_eff;
	logic                     first_eff;
	logic                     data_xfer;
	logic [PIXEL_BYTES_W-1:0] bpp_eff;
	logic [AW-1:0]            rb_last;
	logic [AW-1:0]            col_cur;
	logic                     col_last;
	logic                     use_left;
	logic [BYTE_W-1:0]        above;
	logic [BYTE_W-1:0]        left;
	logic [BYTE_W-1:0]        above_left;
	logic [BYTE_W-1:0]        recon;
	logic                     out_xfer;
	logic                     cfg_wr;
	result_t                  head;

	// ------------------------------------------------------------------
	// apb config port, zero wait states
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_ROW_BYTES) ?
		{{(APB_DATA_W-ROW_BYTES_W){1'b0}}, row_bytes_q} :
		{{(APB_DATA_W-PIXEL_BYTES_W){1'b0}}, pixel_bytes_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PIXEL_BYTES_RST;
			row_bytes_q   <= ROW_BYTES_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROW_BYTES) begin
				row_bytes_q <= pwdata[ROW_BYTES_W-1:0];
			end else begin
				pixel_bytes_q <= pwdata[PIXEL_BYTES_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// effective config: out-of-range values are clamped
	// ------------------------------------------------------------------
	always_comb begin
		if (pixel_bytes_q == '0) begin
			bpp_eff = PIXEL_BYTES_W'(1);
		end else if (32'(pixel_bytes_q) > MAX_PIXEL_BYTES) begin
			bpp_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = pixel_bytes_q;
		end
		if (row_bytes_q == '0) begin
			rb_last = '0;
		end else if (32'(row_bytes_q) > MAX_ROW_BYTES) begin
			rb_last = AW'(MAX_ROW_BYTES - 1);
		end else begin
			rb_last = AW'(row_bytes_q - 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// input side: filter bytes update the row state, data bytes read the
	// line store and enter the reconstruct stage
	// ------------------------------------------------------------------
	assign in_xfer   = s_tvalid & s_tready;
	// an image start forces a new filter byte and drops any partial row
	assign await_eff = awaiting_q | s_tuser[0];
	assign first_eff = first_row_q | s_tuser[0];
	assign data_xfer = in_xfer & ~await_eff;
	assign col_cur   = (col_q > rb_last) ? rb_last : col_q;
	assign col_last  = (col_cur == rb_last);
	// left neighbors exist only once a whole pixel of this row has passed
	assign use_left  = (32'(col_cur) >= 32'(bpp_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b1;
			first_row_q <= 1'b1;
			col_q       <= '0;
			filter_q    <= FILTER_NONE;
		end else if (in_xfer) begin
			if (await_eff) begin
				filter_q    <= (s_tdata > BYTE_W'(FILTER_PAETH)) ?
					FILTER_BAD : filter_t'(s_tdata[2:0]);
				awaiting_q  <= 1'b0;
				first_row_q <= first_eff;
				col_q       <= '0;
			end else if (col_last) begin
				awaiting_q  <= 1'b1;
				first_row_q <= 1'b0;
				col_q       <= '0;
			end else begin
				col_q <= col_cur + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= data_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (data_xfer) begin
			raw_s1      <= s_tdata;
			col_s1      <= col_cur;
			last_s1     <= col_last;
			first_s1    <= first_eff;
			filter_s1   <= filter_q;
			use_left_s1 <= use_left;
			hidx_s1     <= HW'(bpp_eff - 1'b1);
			// a write to the same column in this cycle is not seen by the read
			fwd_s1      <= valid_s1 && (col_s1 == col_cur);
			fwd_data_s1 <= recon;
		end
	end

	// line store: one read at acceptance, one write-back from the stage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			row_mem_q[col_s1] <= recon;
		end
		if (data_xfer) begin
			rd_data_s1 <= row_mem_q[col_cur];
		end
	end

	// ------------------------------------------------------------------
	// reconstruct stage
	// ------------------------------------------------------------------
	always_comb begin
		if (first_s1) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwd_data_s1;
		end else begin
			above = rd_data_s1;
		end
		left       = use_left_s1 ? left_hist_q[hidx_s1] : '0;
		above_left = (use_left_s1 && !first_s1) ? upper_hist_q[hidx_s1] : '0;
	end

	pngu_predict u_predict (
		.filt       (filter_s1),
		.raw        (raw_s1),
		.left       (left),
		.above      (above),
		.above_left (above_left),
		.recon      (recon)
	);

	// newest first; entries older than this row are never selected
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			left_hist_q[0]  <= recon;
			upper_hist_q[0] <= above;
			for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
				left_hist_q[i]  <= left_hist_q[i-1];
				upper_hist_q[i] <= upper_hist_q[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// output fifo; the stage pushes every cycle it holds a byte
	// ------------------------------------------------------------------
	assign out_xfer = m_tvalid & m_tready;
	assign s_tready = (cnt_q + OF_CW'(valid_s1)) < OF_CW'(OF_DEPTH);
	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = head.pixel_byte;
	assign m_tlast  = head.row_end;
	assign m_tuser  = head.bad_filter;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wr_ptr_q] <= '{
				bad_filter: (filter_s1 == FILTER_BAD),
				row_end:    last_s1,
				pixel_byte: recon
			};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + OF_CW'(valid_s1) - OF_CW'(out_xfer);
		end
	end

endmodule

// ===== rtl/pngu_predict.sv =====
// ----------------------------------------------------------------------------
// pngu_predict
// predictor selection and byte reconstruction for one filtered byte
// ----------------------------------------------------------------------------
module pngu_predict
	import pngu_pkg::*;
(
	input  filter_t           filt,
	input  logic [BYTE_W-1:0] raw,
	input  logic [BYTE_W-1:0] left,
	input  logic [BYTE_W-1:0] above,
	input  logic [BYTE_W-1:0] above_left,
	output logic [BYTE_W-1:0] recon
);

	logic [BYTE_W:0]   sum_ab;
	logic [BYTE_W:0]   twice_c;
	logic [BYTE_W-1:0] dist_a;
	logic [BYTE_W-1:0] dist_b;
	logic [BYTE_W:0]   dist_c;
	logic [BYTE_W-1:0] paeth;
	logic [BYTE_W-1:0] pred;

	always_comb begin
		sum_ab  = {1'b0, left} + {1'b0, above};
		twice_c = {above_left, 1'b0};
		// distances of a, b, c from p = a + b - c
		dist_a  = (above > above_left) ? (above - above_left) : (above_left - above);
		dist_b  = (left > above_left) ? (left - above_left) : (above_left - left);
		dist_c  = (sum_ab > twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
		// ties go to left, then above
		if (({1'b0, dist_a} <= {1'b0, dist_b}) && ({1'b0, dist_a} <= dist_c)) begin
			paeth = left;
		end else if ({1'b0, dist_b} <= dist_c) begin
			paeth = above;
		end else begin
			paeth = above_left;
		end
		unique case (filt)
			FILTER_SUB:     pred = left;
			FILTER_UP:      pred = above;
			FILTER_AVERAGE: pred = sum_ab[BYTE_W:1];
			FILTER_PAETH:   pred = paeth;
			default:        pred = '0;
		endcase
		recon = raw + pred;
	end

endmodule

// ===== rtl/pngu_checker.sv =====
// ----------------------------------------------------------------------------
// pngu_checker
// port-level checks for the png scanline unfilter, bound to the top level
// ----------------------------------------------------------------------------
module pngu_checker
	import pngu_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [BYTE_W-1:0] m_tdata,
	input logic              m_tlast,
	input logic [0:0]        m_tuser,
	input logic              pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output changed while stalled");

	// a result only appears on m_tvalid behind an earlier input transfer
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output appeared without an input transfer");

	// with nothing queued the input side must be open
	a_no_deadlock: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser),
	.pready   (pready)
);
